// ----- src/rrts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and constants of the round-robin thread scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int RATE_W     = 10;
    localparam int RATE_RESET = 100;
    localparam int ID_W       = 32;
    localparam int TIME_W     = 64;
    localparam int MS_W       = 32;
    localparam int PROD_W     = MS_W + RATE_W;
    localparam int DIV_K      = 1000;
    localparam int OUT_SLOT_W = 4;
    localparam int OUT_LIVE_W = 5;

    typedef enum logic [1:0] {
        ST_READY = 2'd0,
        ST_RUN   = 2'd1,
        ST_SLEEP = 2'd2,
        ST_DEAD  = 2'd3
    } t_slot_st;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_CREATE = 3'd1,
        ACT_YIELD  = 3'd2,
        ACT_SLEEP  = 3'd3,
        ACT_EXIT   = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_SLOT = 2'd1,
        STAT_HALTED  = 2'd2
    } t_status;

endpackage

// ----- src/rrts_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/rrts_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_div
// Division by the constant 1000 through a reciprocal multiplication, built
// from four 20 by 20 bit partial products, one per cycle.
// ----------------------------------------------------------------------------
module rrts_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rrts_pkg::PROD_W-1:0] i_dividend,
    output logic                        o_done,
    output logic [rrts_pkg::PROD_W-1:0] o_quot
);
    import rrts_pkg::*;

    // x / 1000 equals (x >> 3) / 125, and for every 39-bit value that is the
    // top bits of (x >> 3) * ceil(2^46 / 125) from bit 46 up.
    localparam int                DIV_SH = 3;
    localparam int                D_W    = PROD_W - DIV_SH;
    localparam int                REC_SH = 46;
    localparam int                HALF   = 20;
    localparam int                ACC_W  = 4 * HALF;
    localparam logic [2*HALF-1:0] REC_M  = 40'd562949953422;

    logic              r_busy;
    logic              r_done;
    logic [1:0]        r_cnt;
    logic [D_W-1:0]    r_d;
    logic [ACC_W-1:0]  r_acc;
    logic [HALF-1:0]   w_d_lo;
    logic [HALF-1:0]   w_d_hi;
    logic [HALF-1:0]   w_a;
    logic [HALF-1:0]   w_b;
    logic [2*HALF-1:0] w_pp;
    logic [ACC_W-1:0]  w_pp_sh;

    assign w_d_lo = r_d[HALF-1:0];
    assign w_d_hi = HALF'(r_d[D_W-1:HALF]);

    always_comb begin
        case (r_cnt)
            2'd0: begin
                w_a = w_d_lo;
                w_b = REC_M[HALF-1:0];
            end
            2'd1: begin
                w_a = w_d_lo;
                w_b = REC_M[2*HALF-1:HALF];
            end
            2'd2: begin
                w_a = w_d_hi;
                w_b = REC_M[HALF-1:0];
            end
            default: begin
                w_a = w_d_hi;
                w_b = REC_M[2*HALF-1:HALF];
            end
        endcase
    end

    assign w_pp = w_a * w_b;

    always_comb begin
        case (r_cnt)
            2'd0:       w_pp_sh = {(2*HALF)'(0), w_pp};
            2'd1, 2'd2: w_pp_sh = {HALF'(0), w_pp, HALF'(0)};
            default:    w_pp_sh = {w_pp, (2*HALF)'(0)};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 2'd3) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d   <= i_dividend[PROD_W-1:DIV_SH];
            r_acc <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_pp_sh;
            r_cnt <= r_cnt + 2'd1;
        end
    end

    assign o_done = r_done;
    assign o_quot = PROD_W'(r_acc[ACC_W-1:REC_SH]);

endmodule

// ----- src/round_robin_thread_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// Thread slot table with a circular run ring, round-robin yield and sleep
// deadlines, held in one two-port RAM.
// ----------------------------------------------------------------------------
// One item is taken at a time. The slot table lives in a RAM with a registered
// read port, so every visited slot takes a read state that sets the address
// and an evaluate state that uses the data and writes back. Tick, unknown
// actions and any action once halted go straight to the done state. Create
// scans the slots up to and including the lowest dead slot, then walks the
// ring members to find the tail; a create into a full table scans every slot.
// Yield walks the ring slot by slot, with one more slot visit when the running
// thread changes. Sleep is a yield preceded by the multiply and the division
// by 1000. Exit walks the ring members to find the predecessor and then reads
// the new head, or ends at once when the last thread leaves. The result waits
// in an output register; the next item is taken once the block has moved its
// result there. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler #(
    parameter int SLOT_COUNT = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [2:0]                      i_action,
    input  logic [rrts_pkg::MS_W-1:0]       i_sleep_ms,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rrts_pkg::RATE_W-1:0]     i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [1:0]                      o_status,
    output logic [rrts_pkg::OUT_SLOT_W-1:0] o_running_slot,
    output logic [rrts_pkg::ID_W-1:0]       o_running_id,
    output logic                            o_switched,
    output logic [rrts_pkg::OUT_SLOT_W-1:0] o_from_slot,
    output logic [rrts_pkg::OUT_SLOT_W-1:0] o_new_slot,
    output logic [rrts_pkg::ID_W-1:0]       o_new_id,
    output logic [rrts_pkg::OUT_LIVE_W-1:0] o_alive_count
);
    import rrts_pkg::*;

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);

    typedef struct packed {
        t_slot_st          st;
        logic [ID_W-1:0]   id;
        logic [SW-1:0]     link;
        logic [TIME_W-1:0] dl;
    } t_word;

    localparam int WW = $bits(t_word);

    typedef enum logic [18:0] {
        S_IDLE    = 19'h00001,
        S_SCAN_RD = 19'h00002,
        S_SCAN_EV = 19'h00004,
        S_NEW_WR  = 19'h00008,
        S_TAIL_RD = 19'h00010,
        S_TAIL_EV = 19'h00020,
        S_MUL     = 19'h00040,
        S_DIV     = 19'h00080,
        S_CUR_RD  = 19'h00100,
        S_CUR_EV  = 19'h00200,
        S_WALK_RD = 19'h00400,
        S_WALK_EV = 19'h00800,
        S_FROM_RD = 19'h01000,
        S_FROM_EV = 19'h02000,
        S_UNL_RD  = 19'h04000,
        S_UNL_EV  = 19'h08000,
        S_HEAD_RD = 19'h10000,
        S_HEAD_EV = 19'h20000,
        S_DONE    = 19'h40000
    } t_state;

    function automatic t_word rst_word(input logic [SW-1:0] a);
        t_word w;
        w.st   = ST_DEAD;
        w.id   = '0;
        w.link = '0;
        w.dl   = '0;
        if (a == '0) begin
            w.st = ST_RUN;
            w.id = ID_W'(1);
        end
        return w;
    endfunction

    // Control state.
    t_state             r_state, n_state;
    logic [SW-1:0]      r_cur, n_cur;
    logic [ID_W-1:0]    r_cur_id, n_cur_id;
    logic [SW-1:0]      r_head, n_head;
    logic               r_empty, n_empty;
    logic [ID_W-1:0]    r_next_id, n_next_id;
    logic [CW-1:0]      r_live, n_live;
    logic [TIME_W-1:0]  r_now, n_now;
    logic               r_halted, n_halted;
    logic [RATE_W-1:0]  r_rate;
    logic [SLOT_COUNT-1:0] r_vld;
    logic               r_ovld, n_ovld;

    // Per-item working registers.
    logic [SW-1:0]      r_addr, n_addr;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [SW-1:0]      r_start, n_start;
    logic [SW-1:0]      r_slot, n_slot;
    logic [SW-1:0]      r_from, n_from;
    logic [2:0]         r_op, n_op;
    logic [MS_W-1:0]    r_ms, n_ms;
    logic [TIME_W-1:0]  r_dl, n_dl;
    t_status            r_status, n_status;
    logic               r_sw, n_sw;
    logic [SW-1:0]      r_new_slot, n_new_slot;
    logic [ID_W-1:0]    r_new_id, n_new_id;

    // Output payload.
    t_status                r_o_status, n_o_status;
    logic [OUT_SLOT_W-1:0]  r_o_run_slot, n_o_run_slot;
    logic [ID_W-1:0]        r_o_run_id, n_o_run_id;
    logic                   r_o_sw, n_o_sw;
    logic [OUT_SLOT_W-1:0]  r_o_from, n_o_from;
    logic [OUT_SLOT_W-1:0]  r_o_new_slot, n_o_new_slot;
    logic [ID_W-1:0]        r_o_new_id, n_o_new_id;
    logic [OUT_LIVE_W-1:0]  r_o_live, n_o_live;

    // RAM read side.
    logic               r_rd_vld;
    logic [SW-1:0]      r_rd_addr;
    logic [WW-1:0]      w_ram_q;
    t_word              w_rword;
    logic               w_we;
    logic [SW-1:0]      w_waddr;
    t_word              w_wdata;
    logic               w_wake;

    logic               w_div_start;
    logic               w_div_done;
    logic [PROD_W-1:0]  w_div_quot;
    logic [PROD_W-1:0]  w_prod;

    logic [SW+OUT_SLOT_W-1:0] w_cur_ext;
    logic [SW+OUT_SLOT_W-1:0] w_from_ext;
    logic [SW+OUT_SLOT_W-1:0] w_new_ext;
    logic [CW+OUT_LIVE_W-1:0] w_live_ext;

    rrts_ram #(
        .WIDTH (WW),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_ram_q)
    );

    assign w_prod      = PROD_W'(r_ms) * PROD_W'(r_rate);
    assign w_div_start = (r_state == S_MUL);

    rrts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_prod),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    // Entries never written read as their reset contents.
    assign w_rword = r_rd_vld ? t_word'(w_ram_q) : rst_word(r_rd_addr);
    assign w_wake  = (w_rword.st == ST_SLEEP) && (w_rword.dl <= r_now);

    assign w_cur_ext  = {OUT_SLOT_W'(0), r_cur};
    assign w_from_ext = {OUT_SLOT_W'(0), r_from};
    assign w_new_ext  = {OUT_SLOT_W'(0), r_new_slot};
    assign w_live_ext = {OUT_LIVE_W'(0), r_live};

    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_cur_id     = r_cur_id;
        n_head       = r_head;
        n_empty      = r_empty;
        n_next_id    = r_next_id;
        n_live       = r_live;
        n_now        = r_now;
        n_halted     = r_halted;
        n_ovld       = r_ovld && i_out_stall;
        n_addr       = r_addr;
        n_cnt        = r_cnt;
        n_start      = r_start;
        n_slot       = r_slot;
        n_from       = r_from;
        n_op         = r_op;
        n_ms         = r_ms;
        n_dl         = r_dl;
        n_status     = r_status;
        n_sw         = r_sw;
        n_new_slot   = r_new_slot;
        n_new_id     = r_new_id;
        n_o_status   = r_o_status;
        n_o_run_slot = r_o_run_slot;
        n_o_run_id   = r_o_run_id;
        n_o_sw       = r_o_sw;
        n_o_from     = r_o_from;
        n_o_new_slot = r_o_new_slot;
        n_o_new_id   = r_o_new_id;
        n_o_live     = r_o_live;
        w_we         = 1'b0;
        w_waddr      = r_addr;
        w_wdata      = w_rword;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op       = i_action;
                    n_ms       = i_sleep_ms;
                    n_from     = r_cur;
                    n_status   = STAT_OK;
                    n_sw       = 1'b0;
                    n_new_slot = '0;
                    n_new_id   = '0;
                    n_cnt      = '0;
                    n_state    = S_DONE;
                    if (r_halted) begin
                        n_status = STAT_HALTED;
                    end else begin
                        case (i_action)
                            ACT_TICK: begin
                                n_now = r_now + TIME_W'(1);
                            end
                            ACT_CREATE: begin
                                n_addr  = '0;
                                n_state = S_SCAN_RD;
                            end
                            ACT_YIELD, ACT_EXIT: begin
                                n_addr  = r_cur;
                                n_state = S_CUR_RD;
                            end
                            ACT_SLEEP: begin
                                n_state = S_MUL;
                            end
                            default: begin
                                n_state = S_DONE;
                            end
                        endcase
                    end
                end
            end

            S_SCAN_RD: n_state = S_SCAN_EV;

            S_SCAN_EV: begin
                if (w_rword.st == ST_DEAD) begin
                    n_slot  = r_addr;
                    n_state = S_NEW_WR;
                end else if (r_addr == SW'(SLOT_COUNT - 1)) begin
                    n_status = STAT_NO_SLOT;
                    n_state  = S_DONE;
                end else begin
                    n_addr  = r_addr + SW'(1);
                    n_state = S_SCAN_RD;
                end
            end

            S_NEW_WR: begin
                w_we         = 1'b1;
                w_waddr      = r_slot;
                w_wdata.st   = ST_READY;
                w_wdata.id   = r_next_id;
                w_wdata.link = r_empty ? r_slot : r_head;
                w_wdata.dl   = '0;
                n_new_slot   = r_slot;
                n_new_id     = r_next_id;
                n_next_id    = r_next_id + ID_W'(1);
                n_live       = r_live + CW'(1);
                if (r_empty) begin
                    n_head  = r_slot;
                    n_empty = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_addr  = r_head;
                    n_cnt   = '0;
                    n_state = S_TAIL_RD;
                end
            end

            S_TAIL_RD: n_state = S_TAIL_EV;

            S_TAIL_EV: begin
                if (w_rword.link == r_head || r_cnt == CW'(SLOT_COUNT)) begin
                    w_we         = 1'b1;
                    w_wdata.link = r_slot;
                    n_state      = S_DONE;
                end else begin
                    n_addr  = w_rword.link;
                    n_cnt   = r_cnt + CW'(1);
                    n_state = S_TAIL_RD;
                end
            end

            S_MUL: n_state = S_DIV;

            S_DIV: begin
                if (w_div_done) begin
                    n_dl    = r_now + TIME_W'(w_div_quot) + TIME_W'(1);
                    n_addr  = r_cur;
                    n_state = S_CUR_RD;
                end
            end

            S_CUR_RD: n_state = S_CUR_EV;

            S_CUR_EV: begin
                n_start = w_rword.link;
                n_cnt   = '0;
                if (r_op == ACT_EXIT) begin
                    w_we       = 1'b1;
                    w_wdata.st = ST_DEAD;
                    n_slot     = r_cur;
                    if (r_live != '0) begin
                        n_live = r_live - CW'(1);
                    end
                    if (r_empty) begin
                        n_halted = 1'b1;
                        n_status = STAT_HALTED;
                        n_state  = S_DONE;
                    end else if (r_head == r_cur && w_rword.link == r_cur) begin
                        // Last thread in the ring leaves: the scheduler stops.
                        n_empty  = 1'b1;
                        n_halted = 1'b1;
                        n_status = STAT_HALTED;
                        n_state  = S_DONE;
                    end else begin
                        n_addr  = w_rword.link;
                        n_state = S_UNL_RD;
                    end
                end else begin
                    if (r_op == ACT_SLEEP) begin
                        w_we       = 1'b1;
                        w_wdata.st = ST_SLEEP;
                        w_wdata.dl = r_dl;
                    end
                    if (r_empty) begin
                        n_state = S_DONE;
                    end else begin
                        n_addr  = w_rword.link;
                        n_state = S_WALK_RD;
                    end
                end
            end

            S_WALK_RD: n_state = S_WALK_EV;

            S_WALK_EV: begin
                if (w_wake) begin
                    w_we       = 1'b1;
                    w_wdata.st = ST_READY;
                end
                if (w_wake || w_rword.st == ST_READY || w_rword.st == ST_RUN) begin
                    if (r_addr == r_cur) begin
                        n_state = S_DONE;
                    end else begin
                        w_we       = 1'b1;
                        w_wdata.st = ST_RUN;
                        n_cur      = r_addr;
                        n_cur_id   = w_rword.id;
                        n_sw       = 1'b1;
                        n_addr     = r_from;
                        n_state    = S_FROM_RD;
                    end
                end else if (r_cnt == CW'(SLOT_COUNT - 1) || w_rword.link == r_start) begin
                    n_state = S_DONE;
                end else begin
                    n_addr  = w_rword.link;
                    n_cnt   = r_cnt + CW'(1);
                    n_state = S_WALK_RD;
                end
            end

            S_FROM_RD: n_state = S_FROM_EV;

            S_FROM_EV: begin
                if (w_rword.st == ST_RUN) begin
                    w_we       = 1'b1;
                    w_wdata.st = ST_READY;
                end
                n_state = S_DONE;
            end

            S_UNL_RD: n_state = S_UNL_EV;

            S_UNL_EV: begin
                if (w_rword.link == r_slot || r_cnt == CW'(SLOT_COUNT)) begin
                    w_we         = 1'b1;
                    w_wdata.link = r_start;
                    if (r_head == r_slot) begin
                        n_head = r_start;
                        n_addr = r_start;
                    end else begin
                        n_addr = r_head;
                    end
                    n_state = S_HEAD_RD;
                end else begin
                    n_addr  = w_rword.link;
                    n_cnt   = r_cnt + CW'(1);
                    n_state = S_UNL_RD;
                end
            end

            S_HEAD_RD: n_state = S_HEAD_EV;

            S_HEAD_EV: begin
                w_we       = 1'b1;
                w_wdata.st = ST_RUN;
                n_cur      = r_addr;
                n_cur_id   = w_rword.id;
                n_sw       = 1'b1;
                n_state    = S_DONE;
            end

            S_DONE: begin
                if (!r_ovld || !i_out_stall) begin
                    n_ovld       = 1'b1;
                    n_o_status   = r_status;
                    n_o_run_slot = r_halted ? '0 : w_cur_ext[OUT_SLOT_W-1:0];
                    n_o_run_id   = r_halted ? '0 : r_cur_id;
                    n_o_sw       = r_sw;
                    n_o_from     = w_from_ext[OUT_SLOT_W-1:0];
                    n_o_new_slot = w_new_ext[OUT_SLOT_W-1:0];
                    n_o_new_id   = r_new_id;
                    n_o_live     = w_live_ext[OUT_LIVE_W-1:0];
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cur     <= '0;
            r_cur_id  <= ID_W'(1);
            r_head    <= '0;
            r_empty   <= 1'b0;
            r_next_id <= ID_W'(2);
            r_live    <= CW'(1);
            r_now     <= '0;
            r_halted  <= 1'b0;
            r_rate    <= RATE_W'(RATE_RESET);
            r_vld     <= '0;
            r_ovld    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur     <= n_cur;
            r_cur_id  <= n_cur_id;
            r_head    <= n_head;
            r_empty   <= n_empty;
            r_next_id <= n_next_id;
            r_live    <= n_live;
            r_now     <= n_now;
            r_halted  <= n_halted;
            r_ovld    <= n_ovld;
            if (i_cfg_valid) begin
                r_rate <= i_cfg_data;
            end
            if (w_we) begin
                r_vld[w_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_cnt        <= n_cnt;
        r_start      <= n_start;
        r_slot       <= n_slot;
        r_from       <= n_from;
        r_op         <= n_op;
        r_ms         <= n_ms;
        r_dl         <= n_dl;
        r_status     <= n_status;
        r_sw         <= n_sw;
        r_new_slot   <= n_new_slot;
        r_new_id     <= n_new_id;
        r_o_status   <= n_o_status;
        r_o_run_slot <= n_o_run_slot;
        r_o_run_id   <= n_o_run_id;
        r_o_sw       <= n_o_sw;
        r_o_from     <= n_o_from;
        r_o_new_slot <= n_o_new_slot;
        r_o_new_id   <= n_o_new_id;
        r_o_live     <= n_o_live;
        r_rd_vld     <= r_vld[r_addr];
        r_rd_addr    <= r_addr;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_ovld;
    assign o_status       = r_o_status;
    assign o_running_slot = r_o_run_slot;
    assign o_running_id   = r_o_run_id;
    assign o_switched     = r_o_sw;
    assign o_from_slot    = r_o_from;
    assign o_new_slot     = r_o_new_slot;
    assign o_new_id       = r_o_new_id;
    assign o_alive_count  = r_o_live;

`ifndef ASSERT_OFF
    a_empty_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty == r_halted)
        else $error("ring empty flag and halted flag disagree");

    a_live_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_halted |-> r_live != '0)
        else $error("running scheduler with no live thread");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CW'(SLOT_COUNT))
        else $error("live count exceeds slot count");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside the sleep divide step");
`endif

endmodule
